/* rtl/npp_pkg.sv */
package npp_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 13;
    localparam int ZOOM_W     = 5;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int DIST_W     = 28;
    localparam int STAT_W     = 2;
    localparam int OP_W       = 2;
    localparam int STEP_W     = $clog2(COORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_PICK   = 2'd2,
        OP_MOVE   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] num_x;
        logic signed [COORD_W-1:0] num_y;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] quo_x;
        logic signed [COORD_W-1:0] quo_y;
    } t_div_res;

endpackage

/* rtl/npp_div.sv */
module npp_div
    import npp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [ZOOM_W-1:0] i_zoom,
    output t_div_res          o_res
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [ZOOM_W-1:0]   r_div;
    logic [COORD_W-1:0]  r_mag [2];
    logic [ZOOM_W-1:0]   r_rem [2];
    logic                r_neg [2];

    logic [COORD_W-1:0]  n_mag [2];
    logic [ZOOM_W-1:0]   n_rem [2];
    logic [ZOOM_W:0]     trial [2];
    logic                fits  [2];
    logic signed [COORD_W-1:0] num [2];

    assign num[0] = i_req.num_x;
    assign num[1] = i_req.num_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = {r_rem[l], r_mag[l][COORD_W-1]};
            fits[l]  = trial[l] >= {1'b0, r_div};
            n_rem[l] = fits[l] ? ZOOM_W'(trial[l] - {1'b0, r_div}) : trial[l][ZOOM_W-1:0];
            n_mag[l] = {r_mag[l][COORD_W-2:0], fits[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= (i_zoom == '0) ? ZOOM_W'(1) : i_zoom;
            for (int l = 0; l < 2; l++) begin
                r_neg[l] <= num[l][COORD_W-1];
                r_mag[l] <= num[l][COORD_W-1] ? COORD_W'(-num[l]) : COORD_W'(num[l]);
                r_rem[l] <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_mag[l] <= n_mag[l];
                r_rem[l] <= n_rem[l];
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.quo_x = r_neg[0] ? -$signed(r_mag[0]) : $signed(r_mag[0]);
    assign o_res.quo_y = r_neg[1] ? -$signed(r_mag[1]) : $signed(r_mag[1]);

endmodule

/* rtl/nearest_point_picker.sv */
// Point table with nearest-point picking by smallest squared distance.
// The input channel carries one operation per transfer: the kind in
// s_axis_tuser (clear, append, pick, move) and the x and y coordinates in
// s_axis_tdata. Every input transfer yields exactly one result transfer on
// the output channel: current index, point count and best distance in
// m_axis_tdata, and the status code in m_axis_tuser.
// Operations run one at a time, so an input transfer is accepted only while
// the block is idle. For clear and append the block goes from idle to the
// finish state, which loads the output register once it is free. Pick and
// move first divide both coordinates by the zoom register in a shared
// bit-serial divider; move then writes the point memory, and pick scans the
// point memory once, one entry per cycle through a three-stage read, square
// and compare pipeline. Pick or move on an empty table skips the divider and
// reports the empty status.
// A finished result sits in an output register; the next operation is
// accepted while it waits, and its own result is held until the receiver
// takes the earlier one. Reset empties the table, selects index zero and sets
// the zoom to one; the point memory itself is not cleared.
module nearest_point_picker
    import npp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_zoom_we,
    input  logic [ZOOM_W-1:0]        i_zoom_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,   // coord_x, coord_y
    input  logic [OP_W-1:0]          s_axis_tuser,   // operation
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [55:0]              m_axis_tdata,   // point_index, points_held, best_distance
    output logic [STAT_W-1:0]        m_axis_tuser    // status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SCAN = 5'b00100,
        S_FIN  = 5'b01000,
        S_MOVE = 5'b10000
    } t_state;

    typedef logic [2*COORD_W-1:0] t_point;

    t_point mem [MAX_POINTS];

    t_state                    r_state, n_state;
    logic [ZOOM_W-1:0]         r_zoom;
    logic [CNT_W-1:0]          r_total, n_total;
    logic [IDX_W-1:0]          r_sel, n_sel;
    t_op                       r_op;
    logic signed [COORD_W-1:0] r_qx, r_qy;
    t_status                   r_res_status, n_res_status;
    logic [SUM_W-1:0]          r_res_dist, n_res_dist;

    logic [CNT_W-1:0]          r_rd_idx;
    logic                      rd_issue;
    t_point                    r_rd_data;
    logic                      r_v1, r_v2;
    logic [IDX_W-1:0]          r_idx1, r_idx2;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [SUM_W-1:0]          r_best;
    logic [IDX_W-1:0]          r_best_idx;

    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_index;
    logic [CNT_W-1:0]          r_out_total;
    logic [SUM_W-1:0]          r_out_dist;
    t_status                   r_out_status;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    t_point                    mem_wdata;

    logic                      in_xfer;
    logic                      out_free;
    t_op                       in_op;
    t_div_req                  div_req;
    t_div_res                  div_res;

    logic signed [DIFF_W-1:0]  dx, dy;
    logic signed [2*DIFF_W-1:0] px, py;
    logic [SUM_W-1:0]          sum;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_op'(s_axis_tuser);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign rd_issue      = (r_state == S_SCAN) && (r_rd_idx < r_total);

    assign div_req.start = in_xfer && (in_op == OP_PICK || in_op == OP_MOVE) && (r_total != '0);
    assign div_req.num_x = $signed(s_axis_tdata[COORD_W-1:0]);
    assign div_req.num_y = $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);

    npp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_zoom  (r_zoom),
        .o_res   (div_res)
    );

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_sel        = r_sel;
        n_res_status = r_res_status;
        n_res_dist   = r_res_dist;
        mem_we       = 1'b0;
        mem_waddr    = r_total[IDX_W-1:0];
        mem_wdata    = s_axis_tdata[2*COORD_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_status = ST_OK;
                    n_res_dist   = '0;
                    n_state      = S_FIN;
                    unique case (in_op)
                        OP_CLEAR: begin
                            n_total = '0;
                            n_sel   = '0;
                        end
                        OP_APPEND: begin
                            if (r_total >= CNT_W'(MAX_POINTS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_total = r_total + 1'b1;
                            end
                        end
                        OP_PICK, OP_MOVE: begin
                            if (r_total == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = (r_op == OP_PICK) ? S_SCAN : S_MOVE;
                end
            end
            S_MOVE: begin
                mem_waddr = r_sel;
                mem_wdata = {r_qy, r_qx};
                mem_we    = ({1'b0, r_sel} < r_total);
                n_state   = S_FIN;
            end
            S_SCAN: begin
                if (!rd_issue && !r_v1 && !r_v2) begin
                    n_sel      = r_best_idx;
                    n_res_dist = r_best;
                    n_state    = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zoom      <= ZOOM_W'(1);
            r_total     <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_sel   <= n_sel;
            if (i_zoom_we) begin
                r_zoom <= i_zoom_wdata;
            end
            r_v1 <= rd_issue;
            r_v2 <= r_v1;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_dist   <= n_res_dist;
        if (in_xfer) begin
            r_op <= in_op;
        end
        if (div_res.done) begin
            r_qx <= div_res.quo_x;
            r_qy <= div_res.quo_y;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_index  <= r_sel;
            r_out_total  <= r_total;
            r_out_dist   <= r_res_dist;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    assign dx = $signed({r_rd_data[COORD_W-1], r_rd_data[COORD_W-1:0]})
              - $signed({r_qx[COORD_W-1], r_qx});
    assign dy = $signed({r_rd_data[2*COORD_W-1], r_rd_data[2*COORD_W-1:COORD_W]})
              - $signed({r_qy[COORD_W-1], r_qy});
    assign px  = dx * dx;
    assign py  = dy * dy;
    assign sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            r_rd_idx <= '0;
        end else if (rd_issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_idx1 <= r_rd_idx[IDX_W-1:0];
        r_idx2 <= r_idx1;
        r_sqx  <= px[SQ_W-1:0];
        r_sqy  <= py[SQ_W-1:0];
        if (r_v2 && (r_idx2 == '0 || sum < r_best)) begin
            r_best     <= sum;
            r_best_idx <= r_idx2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, DIST_W'(r_out_dist), r_out_total, r_out_index};
    assign m_axis_tuser  = r_out_status;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds table size");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) |-> ({1'b0, r_sel} < r_total))
        else $error("current point lies outside the table");

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_v1 && !r_v2))
        else $error("new transfer accepted while scan pipeline busy");

    a_dist_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_dist == '0))
        else $error("nonzero distance reported with a failure status");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

/* sim/tb_top.sv */
module tb_top;
    import npp_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;

    typedef struct packed {
        logic [IDX_W-1:0]  point_index;
        logic [CNT_W-1:0]  points_held;
        logic [DIST_W-1:0] best_distance;
        t_status           status;
    } t_reply;

    class point_table_board;
        logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
        logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
        int unsigned held;
        int unsigned current;
        int unsigned peak_held;
        logic [ZOOM_W-1:0] zoom;
        t_reply replies_due [$];
        int errors;
        int ops_seen [4];

        function new();
            held = 0;
            current = 0;
            peak_held = 0;
            zoom = 1;
            errors = 0;
            foreach (ops_seen[k]) ops_seen[k] = 0;
        endfunction

        function int unzoom(int v);
            int z;
            z = (zoom == 0) ? 1 : int'(zoom);
            return v / z;
        endfunction

        function void note_operation(t_op op, logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y);
            t_reply r;
            int qx, qy, i;
            longint dx, dy, d, best;
            r.best_distance = '0;
            r.status = ST_OK;
            ops_seen[op]++;
            case (op)
                OP_CLEAR: begin
                    held = 0;
                    current = 0;
                end
                OP_APPEND: begin
                    if (held >= MAX_POINTS) begin
                        r.status = ST_FULL;
                    end else begin
                        pt_x[held] = x;
                        pt_y[held] = y;
                        held++;
                    end
                end
                default: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else if (op == OP_PICK) begin
                        qx = unzoom(int'(x));
                        qy = unzoom(int'(y));
                        best = 0;
                        for (i = 0; i < held; i++) begin
                            dx = longint'(pt_x[i]) - qx;
                            dy = longint'(pt_y[i]) - qy;
                            d = dx * dx + dy * dy;
                            if (i == 0 || d < best) begin
                                best = d;
                                current = i;
                            end
                        end
                        r.best_distance = best[DIST_W-1:0];
                    end else if (current < held) begin
                        pt_x[current] = COORD_W'(unzoom(int'(x)));
                        pt_y[current] = COORD_W'(unzoom(int'(y)));
                    end
                end
            endcase
            if (held > peak_held) peak_held = held;
            r.point_index = current[IDX_W-1:0];
            r.points_held = held[CNT_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [DIST_W-1:0] want,
                                    logic [DIST_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reply(logic [55:0] data, logic [STAT_W-1:0] stat);
            t_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, tdata %h tuser %0d",
                         $time, data, stat);
            end else begin
                want = replies_due.pop_front();
                compare_field("point_index", DIST_W'(want.point_index),
                              DIST_W'(data[IDX_W-1:0]));
                compare_field("points_held", DIST_W'(want.points_held),
                              DIST_W'(data[IDX_W +: CNT_W]));
                compare_field("best_distance", want.best_distance,
                              data[IDX_W+CNT_W +: DIST_W]);
                compare_field("status", DIST_W'(want.status), DIST_W'(stat));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_zoom_we = 1'b0;
    logic [ZOOM_W-1:0] i_zoom_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // coord_x, coord_y
    logic [OP_W-1:0]   s_axis_tuser = '0;   // operation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [55:0]       m_axis_tdata;        // point_index, points_held, best_distance
    logic [STAT_W-1:0] m_axis_tuser;        // status

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;
    point_table_board board;

    nearest_point_picker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_zoom_we     (i_zoom_we),
        .i_zoom_wdata  (i_zoom_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_zoom(logic [ZOOM_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_zoom_we <= 1'b1;
        i_zoom_wdata <= value;
        @(posedge i_clk);
        board.zoom = value;
        @(negedge i_clk);
        i_zoom_we <= 1'b0;
    endtask

    task automatic send_op(t_op op, int x, int y);
        if ($urandom_range(59) == 0) wait_drained();
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'b0, y[COORD_W-1:0], x[COORD_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_operation(op, x[COORD_W-1:0], y[COORD_W-1:0]);
    endtask

    function automatic int clamp_coord(int v);
        if (v > 4095) return 4095;
        if (v < -4096) return -4096;
        return v;
    endfunction

    task automatic choose_coords(t_op op, output int x, output int y);
        int zf, j;
        case ($urandom_range(3))
            0: begin
                x = int'($urandom_range(8191)) - 4096;
                y = int'($urandom_range(8191)) - 4096;
            end
            1: begin
                x = int'($urandom_range(48)) - 24;
                y = int'($urandom_range(48)) - 24;
            end
            default: begin
                if (board.held == 0) begin
                    x = int'($urandom_range(8191)) - 4096;
                    y = int'($urandom_range(8191)) - 4096;
                end else begin
                    j = $urandom_range(board.held - 1);
                    zf = (op == OP_APPEND || board.zoom == 0) ? 1 : int'(board.zoom);
                    x = clamp_coord(int'(board.pt_x[j]) * zf + int'($urandom_range(2 * zf)) - zf);
                    y = clamp_coord(int'(board.pt_y[j]) * zf + int'($urandom_range(2 * zf)) - zf);
                end
            end
        endcase
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct, logic [ZOOM_W-1:0] z);
        int k, r, x, y;
        t_op op;
        set_zoom(z);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 4 || (board.held >= 40 && r < 12)) begin
                op = OP_CLEAR;
            end else if (r < 45) begin
                op = OP_APPEND;
            end else if (r < 78) begin
                op = OP_PICK;
            end else begin
                op = OP_MOVE;
            end
            choose_coords(op, x, y);
            send_op(op, x, y);
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_zoom(1);
        send_op(OP_PICK, 5, 5);
        send_op(OP_MOVE, 1, 1);
        send_op(OP_APPEND, -4096, -4096);
        send_op(OP_APPEND, 4095, 4095);
        send_op(OP_APPEND, 0, 0);
        send_op(OP_APPEND, 4095, -4096);
        send_op(OP_APPEND, -4096, 4095);
        send_op(OP_APPEND, 0, 0);
        send_op(OP_PICK, 0, 0);
        send_op(OP_PICK, 4095, 4095);
        send_op(OP_PICK, -4000, -4090);
        send_op(OP_MOVE, -7, 9);
        send_op(OP_PICK, -6, 9);
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_MOVE, 2, 2);
        send_op(OP_APPEND, -4096, -4096);
        send_op(OP_PICK, 4095, 4095);
        send_op(OP_MOVE, 3, 4);
        send_op(OP_PICK, -1, -1);
        set_zoom(16);
        send_op(OP_APPEND, 100, -100);
        send_op(OP_PICK, -4096, 4095);
        send_op(OP_MOVE, -17, 17);
        send_op(OP_PICK, -31, -31);
        set_zoom(0);
        send_op(OP_PICK, -3, 3);
        set_zoom(31);
        send_op(OP_PICK, -4096, 4095);
        send_op(OP_MOVE, 30, -30);

        run_phase(92, 0, 0, 1);
        run_phase(92, 47, 0, 16);
        run_phase(92, 0, 47, ZOOM_W'($urandom_range(15, 2)));
        run_phase(92, 16, 16, 0);
        run_phase(92, 0, 0, 31);
        run_phase(92, 16, 16, ZOOM_W'($urandom_range(16, 1)));

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (board.replies_due.size() != 0) begin
            board.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     board.replies_due.size());
        end
        $display("Covered %0d clears, %0d appends, %0d picks, %0d moves; up to %0d points held.",
                 board.ops_seen[OP_CLEAR], board.ops_seen[OP_APPEND],
                 board.ops_seen[OP_PICK], board.ops_seen[OP_MOVE], board.peak_held);
        $display("Zoom values 0, 1, 16, 31 and random ones, with sender gaps and receiver stalls.");
        if (board.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
